/* rtl/hex_command_parser_with_curve_map_macros.svh */
// assertion macros for the hex command parser with curve map
// used by the top level only, expects clk and rst_n in scope
`ifndef HEX_COMMAND_PARSER_WITH_CURVE_MAP_MACROS_SVH
`define HEX_COMMAND_PARSER_WITH_CURVE_MAP_MACROS_SVH

// same-cycle implication
`define HCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hcp_pkg.sv */
// shared types, codes and hex decode for the hex command parser
// no dependencies
`timescale 1ns / 1ps

package hcp_pkg;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_START   = 3'd1;
    localparam logic [2:0] ST_DIGIT1  = 3'd2;
    localparam logic [2:0] ST_DIGIT2  = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] KNEE_LEVEL = 8'h40;
    localparam logic [7:0] TOP_LEVEL  = 8'hFF;
    localparam logic [7:0] SLOPE_NUM  = 8'd191;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } hex_digit_t;

    typedef struct packed {
        logic [2:0] state;
        logic       done;
        logic [7:0] value;
    } parse_result_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t r;
        r.is_hex = 1'b1;
        r.nibble = 4'd0;
        if (ch inside {[8'h30:8'h39]})
        begin
            r.nibble = ch[3:0];
        end
        else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r.nibble = 4'(ch[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/hcp_parse.sv */
// message state machine and digit nibble registers
// depends on hcp_pkg
`timescale 1ns / 1ps

module hcp_parse
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             ch,
    output hcp_pkg::parse_result_t res
);

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [3:0]          high_reg;
    logic [3:0]          low_reg;
    logic                load_high;
    logic                load_low;
    logic                done;
    hcp_pkg::hex_digit_t hv;

    assign hv = hcp_pkg::hex_decode(ch);

    always_comb
    begin
        state_next = state_reg;
        load_high  = 1'b0;
        load_low   = 1'b0;
        done       = 1'b0;
        case (state_reg)
            hcp_pkg::ST_START:
            begin
                if (hv.is_hex)
                begin
                    load_high  = 1'b1;
                    state_next = hcp_pkg::ST_DIGIT1;
                end
                else
                begin
                    state_next = hcp_pkg::ST_INVALID;
                end
            end
            hcp_pkg::ST_DIGIT1:
            begin
                if (hv.is_hex)
                begin
                    load_low   = 1'b1;
                    state_next = hcp_pkg::ST_DIGIT2;
                end
                else
                begin
                    state_next = hcp_pkg::ST_INVALID;
                end
            end
            hcp_pkg::ST_DIGIT2:
            begin
                if (ch == hcp_pkg::CH_CR || ch == hcp_pkg::CH_LF)
                begin
                    done       = 1'b1;
                    state_next = hcp_pkg::ST_END;
                end
                else
                begin
                    state_next = hcp_pkg::ST_INVALID;
                end
            end
            hcp_pkg::ST_INVALID:
            begin
                if (ch == hcp_pkg::CH_COLON)
                begin
                    state_next = hcp_pkg::ST_START;
                end
            end
            default:
            begin
                // idle, end and unused codes
                state_next = (ch == hcp_pkg::CH_COLON) ? hcp_pkg::ST_START
                                                       : hcp_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcp_pkg::ST_IDLE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_high)
        begin
            high_reg <= hv.nibble;
        end
        if (advance && load_low)
        begin
            low_reg <= hv.nibble;
        end
    end

    assign res.state = state_next;
    assign res.done  = done;
    assign res.value = {high_reg, low_reg};

endmodule

/* rtl/hcp_curve.sv */
// four-segment piecewise-linear level curve
// depends on hcp_pkg
`timescale 1ns / 1ps

module hcp_curve
(
    input  logic [7:0] x,
    output logic [7:0] y
);

    logic [5:0]  d;
    logic [13:0] prod;
    logic [7:0]  scaled;
    logic [7:0]  triple;
    logic [1:0]  corr;

    assign d      = x[5:0];
    assign prod   = 14'(d) * 14'(hcp_pkg::SLOPE_NUM);
    assign scaled = prod[13:6];
    assign triple = 8'({2'b00, d}) + 8'({1'b0, d, 1'b0});

    // 191/63 is 3 plus 2/63
    always_comb
    begin
        if (d == 6'd63)
        begin
            corr = 2'd2;
        end
        else if (d[5])
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
    end

    always_comb
    begin
        case (x[7:6])
            2'd0:    y = x;
            2'd1:    y = hcp_pkg::KNEE_LEVEL + scaled;
            2'd2:    y = hcp_pkg::TOP_LEVEL - scaled;
            2'd3:    y = hcp_pkg::KNEE_LEVEL + triple + 8'(corr);
            default: y = x;
        endcase
    end

endmodule

/* rtl/hex_command_parser_with_curve_map.sv */
// Hex command parser with curve map, top level.
//
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per
// transaction. Output channel: out_valid / out_ready carry one result per
// input byte: parser_state after the byte, message_done, mapped_level.
// Messages are ':' two hex digits (either case) then CR or LF; a completed
// message yields mapped_level from the curve, otherwise mapped_level is 0.
// Each input byte is registered, then parse and curve logic load it into the
// result register. Throughput: one byte per cycle while the receiver takes
// results; the parser state register updates in the same cycle the result
// register loads, so bytes follow back to back.
// When the receiver stalls, the result register holds and the input
// register still takes one byte; in_ready drops only when both are full.
// Reset clears both valid flags and puts the parser in idle; the digit
// registers are loaded before any message can complete.
// Depends on hcp_pkg, hcp_parse, hcp_curve and the macros header.
`timescale 1ns / 1ps
`include "hex_command_parser_with_curve_map_macros.svh"

module hex_command_parser_with_curve_map
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] parser_state,
    output logic       message_done,
    output logic [7:0] mapped_level
);

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   out_valid_reg;
    logic [2:0]             state_out_reg;
    logic                   done_out_reg;
    logic [7:0]             level_out_reg;
    logic                   advance;
    logic [7:0]             curve_level;
    hcp_pkg::parse_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    hcp_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ch      (byte_reg),
        .res     (res)
    );

    hcp_curve u_curve
    (
        .x (res.value),
        .y (curve_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            state_out_reg <= res.state;
            done_out_reg  <= res.done;
            level_out_reg <= res.done ? curve_level : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parser_state = state_out_reg;
    assign message_done = done_out_reg;
    assign mapped_level = level_out_reg;

    `HCP_ASSERT_NOW(a_level_only_when_done, out_valid && !message_done, mapped_level == 8'd0, "level without completed message")
    `HCP_ASSERT_NOW(a_done_means_end, out_valid && message_done, parser_state == hcp_pkg::ST_END, "done without end state")
    `HCP_ASSERT_NOW(a_end_means_done, out_valid && parser_state == hcp_pkg::ST_END, message_done, "end state without done")
    `HCP_ASSERT_NOW(a_stall_only_when_full, !in_ready, in_valid_reg && out_valid && !out_ready, "input stalled with room")

endmodule

/* tb/sv/hex_command_parser_with_curve_map_checker.sv */
// checker for the hex command parser: watches both channels, predicts each result
// from the accepted byte stream and compares it against what the block returns
// depends on hcp_pkg for state codes, character codes and the result struct
`timescale 1ns / 1ps

module hex_command_parser_with_curve_map_checker
    import hcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] parser_state,
    input  logic       message_done,
    input  logic [7:0] mapped_level,
    output int         errors,
    output int         pending,
    output int         messages,
    output int         results
);

    localparam int KNOT_A = 64;
    localparam int KNOT_B = 128;
    localparam int KNOT_C = 192;
    localparam int FULL   = 255;

    logic [2:0]    track_state;
    logic [3:0]    high_digit;
    logic [3:0]    low_digit;
    parse_result_t predicted_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors = errors + 1;
    endtask

    function automatic int hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
        begin
            return int'(ch) - int'("0");
        end
        if (ch >= "a" && ch <= "f")
        begin
            return int'(ch) - int'("a") + 10;
        end
        if (ch >= "A" && ch <= "F")
        begin
            return int'(ch) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic int line_segment(input int x, input int x1, input int y1,
                                        input int x2, input int y2);
        return y1 + ((x - x1) * (y2 - y1)) / (x2 - x1);
    endfunction

    function automatic logic [7:0] curve_level(input logic [7:0] v);
        int x;
        int y;
        x = int'(v);
        if (x < KNOT_A)
        begin
            y = line_segment(x, 0, 0, KNOT_A, KNOT_A);
        end
        else if (x < KNOT_B)
        begin
            y = line_segment(x, KNOT_A, KNOT_A, KNOT_B, FULL);
        end
        else if (x < KNOT_C)
        begin
            y = line_segment(x, KNOT_B, FULL, KNOT_C, KNOT_A);
        end
        else
        begin
            y = line_segment(x, KNOT_C, KNOT_A, FULL, FULL);
        end
        if (y < 0)
        begin
            y = 0;
        end
        if (y > FULL)
        begin
            y = FULL;
        end
        return 8'(y);
    endfunction

    // advances the tracked parser by one byte and returns the result it should give
    function parse_result_t next_parse_result(input logic [7:0] ch);
        parse_result_t r;
        int            digit;
        digit   = hex_nibble(ch);
        r.done  = 1'b0;
        r.value = 8'd0;
        case (track_state)
            ST_START:
            begin
                if (digit >= 0)
                begin
                    high_digit  = 4'(digit);
                    track_state = ST_DIGIT1;
                end
                else
                begin
                    track_state = ST_INVALID;
                end
            end
            ST_DIGIT1:
            begin
                if (digit >= 0)
                begin
                    low_digit   = 4'(digit);
                    track_state = ST_DIGIT2;
                end
                else
                begin
                    track_state = ST_INVALID;
                end
            end
            ST_DIGIT2:
            begin
                if (ch == CH_CR || ch == CH_LF)
                begin
                    track_state = ST_END;
                    r.done      = 1'b1;
                    r.value     = curve_level({high_digit, low_digit});
                end
                else
                begin
                    track_state = ST_INVALID;
                end
            end
            ST_INVALID:
            begin
                if (ch == CH_COLON)
                begin
                    track_state = ST_START;
                end
            end
            default:
            begin
                track_state = (ch == CH_COLON) ? ST_START : ST_INVALID;
            end
        endcase
        r.state = track_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            track_state = ST_IDLE;
            high_digit  = 4'd0;
            low_digit   = 4'd0;
            predicted_results.delete();
            errors   = 0;
            pending  = 0;
            messages = 0;
            results  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results = results + 1;
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction", int'(parser_state), -1);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (parser_state !== want.state)
                    begin
                        report_mismatch("parser_state", int'(parser_state), int'(want.state));
                    end
                    if (message_done !== want.done)
                    begin
                        report_mismatch("message_done", int'(message_done), int'(want.done));
                    end
                    if (mapped_level !== want.value)
                    begin
                        report_mismatch("mapped_level", int'(mapped_level), int'(want.value));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = next_parse_result(rx_byte);
                if (want.done)
                begin
                    messages = messages + 1;
                end
                predicted_results.push_back(want);
            end
            pending = predicted_results.size();
        end
    end

endmodule

/* tb/sv/hex_command_parser_with_curve_map_tb.sv */
// testbench top for the hex command parser with curve map: drives directed and
// random byte streams with random gaps and stalls, and gives the verdict
// depends on hcp_pkg, the block and hex_command_parser_with_curve_map_checker
`timescale 1ns / 1ps

module hex_command_parser_with_curve_map_tb;
    import hcp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1700;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [7:0] DIRECTED_BYTES [24] = '{
        CH_COLON, "0", "0", CH_CR,
        CH_COLON, "f", "F", CH_LF,
        "x", 8'hFF, 8'h00,
        CH_COLON, CH_COLON,
        CH_COLON, "7", CH_COLON,
        CH_COLON, "8", "0", CH_COLON,
        CH_COLON, "C", "0", CH_CR
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] parser_state;
    logic       message_done;
    logic [7:0] mapped_level;

    int mismatches;
    int outstanding;
    int messages_done;
    int results_checked;
    int bytes_sent;
    int cycles;
    bit tx_steady;
    bit rx_steady;

    hex_command_parser_with_curve_map dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parser_state (parser_state),
        .message_done (message_done),
        .mapped_level (mapped_level)
    );

    hex_command_parser_with_curve_map_checker chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parser_state (parser_state),
        .message_done (message_done),
        .mapped_level (mapped_level),
        .errors       (mismatches),
        .pending      (outstanding),
        .messages     (messages_done),
        .results      (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[hex_command_parser_with_curve_map] ERROR");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_byte  <= b;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && in_ready));
        bytes_sent = bytes_sent + 1;
        if (bytes_sent % 130 == 0)
        begin
            tx_steady = !tx_steady;
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [7:0] hex_char(input int nibble, input bit upper);
        if (nibble < 10)
        begin
            return 8'("0" + nibble);
        end
        return upper ? 8'("A" + nibble - 10) : 8'("a" + nibble - 10);
    endfunction

    // mostly well-formed messages with random digits, some corrupted, cut short or noise
    task automatic send_random_traffic();
        logic [7:0] msg [4];
        int         kind;
        int         count;
        int         pos;
        kind   = $urandom_range(0, 9);
        msg[0] = CH_COLON;
        msg[1] = hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        msg[2] = hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        msg[3] = $urandom_range(0, 1) ? CH_CR : CH_LF;
        count  = 4;
        if (kind == 7)
        begin
            pos      = $urandom_range(0, 3);
            msg[pos] = $urandom_range(0, 1) ? CH_COLON : 8'($urandom_range(0, 255));
        end
        else if (kind == 8)
        begin
            count = $urandom_range(1, 3);
        end
        else if (kind == 9)
        begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++)
            begin
                msg[i] = 8'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < count; i++)
        begin
            send_byte(msg[i]);
        end
    endtask

    initial
    begin
        int taken;
        int hold;
        taken     = 0;
        rx_steady = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (taken == 400 || taken == 1200)
            begin
                hold = 80;
            end
            else if (rx_steady)
            begin
                hold = 0;
            end
            else
            begin
                hold = $urandom_range(0, 11);
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && out_ready));
            taken = taken + 1;
            if (taken % 150 == 0)
            begin
                rx_steady = !rx_steady;
            end
        end
    end

    initial
    begin
        int directed_count;
        bytes_sent = 0;
        tx_steady  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_BYTES[i])
        begin
            send_byte(DIRECTED_BYTES[i]);
        end
        directed_count = bytes_sent;
        drain_results();

        while (bytes_sent < directed_count + RANDOM_BYTES / 2)
        begin
            send_random_traffic();
        end
        drain_results();
        while (bytes_sent < directed_count + RANDOM_BYTES)
        begin
            send_random_traffic();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("sent %0d bytes (%0d directed), checked %0d results, %0d completed messages",
                 bytes_sent, directed_count, results_checked, messages_done);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[hex_command_parser_with_curve_map] OK");
        end
        else
        begin
            $display("[hex_command_parser_with_curve_map] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/hcp_pkg.sv
rtl/hcp_parse.sv
rtl/hcp_curve.sv
rtl/hex_command_parser_with_curve_map.sv
tb/sv/hex_command_parser_with_curve_map_checker.sv
tb/sv/hex_command_parser_with_curve_map_tb.sv
